>>> design/char_lcd_bus_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Character LCD bus sequencer assertion macros
// Clocked assertion helpers shared by the sequencer modules.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define CLBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CLBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define CLBS_ASSERT(lbl, clk, rst, prop, msg)

`define CLBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> design/clbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD bus sequencer package
// Field widths, request and job codes, timing constants and the
// initialization step table.
// ----------------------------------------------------------------------------
package clbs_pkg;

   localparam int COLUMNS = 8;
   localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int WAIT_W   = 17;
   localparam int IDX_W    = 4;
   localparam int KIND_W   = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_FOUR_BIT_MODE = '0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CURSOR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INIT   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADDR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INIT  = 3'd4;

   localparam logic [BYTE_W-1:0] CMD_SET_ADDR  = 8'h80;
   localparam logic [BYTE_W-1:0] ROW1_OFFSET   = 8'h40;
   localparam logic [BYTE_W-1:0] CMD_CLEAR     = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME      = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_ENTRY     = 8'h06;
   localparam logic [BYTE_W-1:0] CMD_DISPLAY   = 8'h0c;
   localparam logic [BYTE_W-1:0] CMD_FUNC_8BIT = 8'h38;
   localparam logic [BYTE_W-1:0] CMD_FUNC_4BIT = 8'h28;
   localparam logic [BYTE_W-1:0] CMD_WAKE_8BIT = 8'h30;
   localparam logic [BYTE_W-1:0] NIB_WAKE      = 8'h03;
   localparam logic [BYTE_W-1:0] NIB_SET_4BIT  = 8'h02;
   localparam logic [BYTE_W-1:0] NIB_MASK      = 8'h0f;

   localparam logic [WAIT_W-1:0] PULSE_US      = 17'd1000;
   localparam logic [WAIT_W-1:0] TAIL_SHORT    = 17'd50;
   localparam logic [WAIT_W-1:0] TAIL_SETUP    = 17'd1000;
   localparam logic [WAIT_W-1:0] TAIL_HOME     = 17'd2000;
   localparam logic [WAIT_W-1:0] TAIL_FIRST    = 17'd10000;
   localparam logic [WAIT_W-1:0] WAIT_POWER_ON = 17'd100000;
   localparam logic [WAIT_W-1:0] WAIT_WAKE     = 17'd5000;
   localparam logic [WAIT_W-1:0] WAIT_NIBBLE   = PULSE_US + PULSE_US;
   localparam logic [WAIT_W-1:0] WAIT_SETUP    = PULSE_US + TAIL_SETUP;
   localparam logic [WAIT_W-1:0] WAIT_HOME     = PULSE_US + TAIL_HOME;
   localparam logic [WAIT_W-1:0] WAIT_FIRST    = PULSE_US + TAIL_FIRST;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              four_bit;
      logic [BYTE_W-1:0] data_byte;
      logic              wrap;
      logic              wrap_row;
   } job_type;

   typedef struct packed {
      logic              strobe_res;
      logic              reg_select;
      logic [BYTE_W-1:0] bus_value;
      logic [WAIT_W-1:0] wait_us;
      logic              ok;
      logic              last;
   } step_type;

   function automatic step_type pulse_step(input logic [BYTE_W-1:0] bus,
                                           input logic [WAIT_W-1:0] wait_us,
                                           input logic last);
      step_type s;
      s.strobe_res = 1'b1;
      s.reg_select = 1'b0;
      s.bus_value  = bus;
      s.wait_us    = wait_us;
      s.ok         = 1'b1;
      s.last       = last;
      return s;
   endfunction

   function automatic step_type init_step(input logic four_bit,
                                          input logic [IDX_W-1:0] idx);
      step_type s;
      s = pulse_step('0, '0, 1'b1);
      if (four_bit) begin
         case (idx)
            4'd0:  s = pulse_step('0, WAIT_POWER_ON, 1'b0);
            4'd1:  s = pulse_step(NIB_WAKE, WAIT_WAKE, 1'b0);
            4'd2:  s = pulse_step(NIB_WAKE, WAIT_NIBBLE, 1'b0);
            4'd3:  s = pulse_step(NIB_WAKE, WAIT_NIBBLE, 1'b0);
            4'd4:  s = pulse_step(NIB_WAKE, WAIT_NIBBLE, 1'b0);
            4'd5:  s = pulse_step(NIB_SET_4BIT, WAIT_NIBBLE, 1'b0);
            4'd6:  s = pulse_step(CMD_FUNC_4BIT >> 4, WAIT_NIBBLE, 1'b0);
            4'd7:  s = pulse_step(CMD_FUNC_4BIT & NIB_MASK, WAIT_SETUP, 1'b0);
            4'd8:  s = pulse_step(CMD_DISPLAY >> 4, WAIT_NIBBLE, 1'b0);
            4'd9:  s = pulse_step(CMD_DISPLAY & NIB_MASK, WAIT_SETUP, 1'b0);
            4'd10: s = pulse_step(CMD_ENTRY >> 4, WAIT_NIBBLE, 1'b0);
            4'd11: s = pulse_step(CMD_ENTRY & NIB_MASK, WAIT_SETUP, 1'b0);
            4'd12: s = pulse_step(CMD_HOME >> 4, WAIT_NIBBLE, 1'b0);
            4'd13: s = pulse_step(CMD_HOME & NIB_MASK, WAIT_HOME, 1'b0);
            4'd14: s = pulse_step(CMD_CLEAR >> 4, WAIT_NIBBLE, 1'b0);
            default: s = pulse_step(CMD_CLEAR & NIB_MASK, WAIT_HOME, 1'b1);
         endcase
         if (idx == 4'd0 || idx == 4'd1) begin
            s.strobe_res = 1'b0;
         end
      end else begin
         case (idx)
            4'd0: s = pulse_step('0, WAIT_POWER_ON, 1'b0);
            4'd1: s = pulse_step(CMD_WAKE_8BIT, WAIT_FIRST, 1'b0);
            4'd2: s = pulse_step(CMD_WAKE_8BIT, WAIT_SETUP, 1'b0);
            4'd3: s = pulse_step(CMD_WAKE_8BIT, WAIT_SETUP, 1'b0);
            4'd4: s = pulse_step(CMD_FUNC_8BIT, WAIT_SETUP, 1'b0);
            4'd5: s = pulse_step(CMD_DISPLAY, WAIT_SETUP, 1'b0);
            4'd6: s = pulse_step(CMD_ENTRY, WAIT_SETUP, 1'b0);
            4'd7: s = pulse_step(CMD_HOME, WAIT_HOME, 1'b0);
            default: s = pulse_step(CMD_CLEAR, WAIT_HOME, 1'b1);
         endcase
         if (idx == 4'd0) begin
            s.strobe_res = 1'b0;
         end
      end
      return s;
   endfunction

endpackage

>>> design/clbs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD bus sequencer channels
// Request channel and bus step channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clbs_req_if;
   import clbs_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [BYTE_W-1:0]   char_code;
   logic                row;
   logic [BYTE_W-1:0]   column;

   modport source (output valid, output action, output char_code, output row,
                   output column, input ready);
   modport sink (input valid, input action, input char_code, input row,
                 input column, output ready);
endinterface

interface clbs_rsp_if;
   import clbs_pkg::*;

   logic              valid;
   logic              ready;
   logic              strobe_res;
   logic              reg_select;
   logic [BYTE_W-1:0] bus_value;
   logic [WAIT_W-1:0] wait_us;
   logic              ok;
   logic              last;

   modport source (output valid, output strobe_res, output reg_select,
                   output bus_value, output wait_us, output ok, output last,
                   input ready);
   modport sink (input valid, input strobe_res, input reg_select,
                 input bus_value, input wait_us, input ok, input last,
                 output ready);
endinterface

>>> design/char_lcd_bus_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD bus sequencer
// Expands character, cursor, clear and initialize requests into LCD bus steps.
//
//   channel   dir   handshake            contents
//   req_chan  in    valid/ready          action, char_code, row, column
//   rsp_chan  out   valid/ready          strobe_res, reg_select, bus_value,
//                                        wait_us, ok, last
//   csr_*     in    APB write, pready=1  four_bit_mode at byte address 0
//
// One bus step leaves per cycle from the step sequencer's output register
// while rsp_chan is ready. A request expands into as many steps as it needs:
// character 1 to 4, set cursor 1 to 2, clear 1 to 2, initialize 9 or 16.
// Requests are taken while earlier ones are still sequenced, until the
// two-entry job queue is full; a stalled rsp_chan holds the sequencer only.
// Synchronous reset clears the mode register, cursor, queue and sequencer.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   clbs_req_if.sink                       req_chan,
   clbs_rsp_if.source                     rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [clbs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [clbs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [clbs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import clbs_pkg::*;

   logic                 four_bit_mode_ff;
   logic                 four_bit_mode_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_write;
   logic                 push_valid;
   logic                 push_ready;
   job_type              push_job;
   logic                 pop_valid;
   logic                 pop_ready;
   job_type              pop_job;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_idx == REG_FOUR_BIT_MODE);
   assign four_bit_mode_in = csr_write ? csr_pwdata[0] : four_bit_mode_ff;
   assign csr_prdata = (csr_idx == REG_FOUR_BIT_MODE) ? CSR_DATA_W'(four_bit_mode_ff)
                                                      : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_mode_ff <= 1'b0;
      end else begin
         four_bit_mode_ff <= four_bit_mode_in;
      end
   end

   clbs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .four_bit_mode (four_bit_mode_ff),
      .req_chan      (req_chan),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   clbs_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   clbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> design/clbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, keeps the cursor and turns each request into a job.
// ----------------------------------------------------------------------------
module clbs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              four_bit_mode,
   clbs_req_if.sink          req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output clbs_pkg::job_type push_job
);
   import clbs_pkg::*;

   logic [COL_W-1:0] cursor_column_ff;
   logic [COL_W-1:0] cursor_column_in;
   logic             cursor_row_ff;
   logic             cursor_row_in;
   logic             accept;
   logic [COL_W:0]   col_next;
   logic             col_wrap;
   logic             col_ok;
   logic [BYTE_W-1:0] target_addr;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign accept         = req_chan.valid && push_ready;

   assign col_next    = {1'b0, cursor_column_ff} + (COL_W + 1)'(1);
   assign col_wrap    = col_next >= (COL_W + 1)'(COLUMNS);
   assign col_ok      = req_chan.column < BYTE_W'(COLUMNS);
   assign target_addr = CMD_SET_ADDR | (req_chan.row ? ROW1_OFFSET : '0)
                        | BYTE_W'(req_chan.column[COL_W-1:0]);

   always_comb begin
      push_job           = '0;
      push_job.four_bit  = four_bit_mode;
      push_job.wrap_row  = ~cursor_row_ff;
      cursor_column_in   = cursor_column_ff;
      cursor_row_in      = cursor_row_ff;
      case (req_chan.action)
         ACT_WRITE: begin
            push_job.kind      = KIND_DATA;
            push_job.data_byte = req_chan.char_code;
            push_job.wrap      = col_wrap;
            if (col_wrap) begin
               cursor_column_in = '0;
               cursor_row_in    = ~cursor_row_ff;
            end else begin
               cursor_column_in = col_next[COL_W-1:0];
            end
         end
         ACT_CURSOR: begin
            if (col_ok) begin
               push_job.kind      = KIND_ADDR;
               push_job.data_byte = target_addr;
               cursor_column_in   = req_chan.column[COL_W-1:0];
               cursor_row_in      = req_chan.row;
            end else begin
               push_job.kind = KIND_ERROR;
            end
         end
         ACT_CLEAR: begin
            push_job.kind      = KIND_CLEAR;
            push_job.data_byte = CMD_CLEAR;
         end
         default: begin
            push_job.kind = KIND_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_column_ff <= '0;
         cursor_row_ff    <= 1'b0;
      end else if (accept) begin
         cursor_column_ff <= cursor_column_in;
         cursor_row_ff    <= cursor_row_in;
      end
   end

endmodule

>>> design/clbs_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short register queue between the front end and the step sequencer.
// ----------------------------------------------------------------------------
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  clbs_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output clbs_pkg::job_type pop_job
);
   import clbs_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CLBS_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `CLBS_ASSERT_IMPLIES(a_ptr_track, clock, reset, count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH), wr_ptr_ff == rd_ptr_ff, "queue pointers out of step")

endmodule

>>> design/clbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step sequencer
// Expands queued jobs into bus steps, one step per cycle while rsp_chan is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  clbs_pkg::job_type pop_job,
   clbs_rsp_if.source        rsp_chan
);
   import clbs_pkg::*;

   logic             cur_valid_ff;
   logic             cur_valid_in;
   job_type          cur_job_ff;
   job_type          cur_job_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   step_type         out_step_ff;
   step_type         step;
   logic             advance;

   function automatic step_type byte_step(input job_type job,
                                          input logic [IDX_W-1:0] idx);
      step_type          s;
      logic              bsel;
      logic              final_part;
      logic [BYTE_W-1:0] cur_byte;
      logic [WAIT_W-1:0] tail;
      bsel       = job.four_bit ? idx[1] : idx[0];
      final_part = job.four_bit ? idx[0] : 1'b1;
      cur_byte   = bsel ? (CMD_SET_ADDR | (job.wrap_row ? ROW1_OFFSET : '0))
                        : job.data_byte;
      tail       = (job.kind == KIND_CLEAR) ? TAIL_HOME : TAIL_SHORT;
      s.strobe_res = 1'b1;
      s.reg_select = (job.kind == KIND_DATA) && !bsel;
      s.ok         = 1'b1;
      s.last       = final_part && (bsel == (job.kind == KIND_DATA && job.wrap));
      if (!final_part) begin
         s.bus_value = cur_byte >> 4;
         s.wait_us   = WAIT_NIBBLE;
      end else begin
         s.bus_value = job.four_bit ? (cur_byte & NIB_MASK) : cur_byte;
         s.wait_us   = PULSE_US + tail;
      end
      return s;
   endfunction

   always_comb begin
      if (cur_job_ff.kind == KIND_INIT) begin
         step = init_step(cur_job_ff.four_bit, idx_ff);
      end else if (cur_job_ff.kind == KIND_ERROR) begin
         step      = '0;
         step.last = 1'b1;
      end else begin
         step = byte_step(cur_job_ff, idx_ff);
      end
   end

   assign advance   = cur_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready = !cur_valid_ff || (advance && step.last);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_job_in   = cur_job_ff;
      idx_in       = idx_ff;
      if (pop_valid && pop_ready) begin
         cur_valid_in = 1'b1;
         cur_job_in   = pop_job;
         idx_in       = '0;
      end else if (advance && step.last) begin
         cur_valid_in = 1'b0;
         idx_in       = '0;
      end else if (advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_job_ff <= cur_job_in;
      if (advance) begin
         out_step_ff <= step;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.strobe_res = out_step_ff.strobe_res;
   assign rsp_chan.reg_select = out_step_ff.reg_select;
   assign rsp_chan.bus_value  = out_step_ff.bus_value;
   assign rsp_chan.wait_us    = out_step_ff.wait_us;
   assign rsp_chan.ok         = out_step_ff.ok;
   assign rsp_chan.last       = out_step_ff.last;

   `CLBS_ASSERT_IMPLIES(a_idle_idx, clock, reset, !cur_valid_ff, idx_ff == '0, "step index left over while idle")
   `CLBS_ASSERT_IMPLIES(a_error_single, clock, reset, cur_valid_ff && cur_job_ff.kind == KIND_ERROR, step.last && !step.ok && !step.strobe_res, "error job not a single step")
   `CLBS_ASSERT_IMPLIES(a_last_restart, clock, reset, advance && step.last, ##1 idx_ff == '0, "step index not restarted after last step")

endmodule
